// ===== hw/rtl/bnva_pkg.sv =====
// shared types, widths and the reciprocal square root function of the vote accumulator
`timescale 1ns / 1ps
`default_nettype none
package bnva_pkg;

  localparam int DEF_NUM_IMAGES   = 4096;
  localparam int DEF_MAX_RUN      = 64;
  localparam int DEF_FEATURE_BITS = 24;

  localparam int FEAT_W   = 24;
  localparam int IMAGE_W  = 13;
  localparam int WEIGHT_W = 24;
  localparam int SCORE_W  = 40;
  localparam int SUM_W    = 31;
  localparam int ROM_W    = 16;
  localparam int AMOUNT_W = 32;
  localparam int PROD_W   = SUM_W + ROM_W;
  localparam int IMG_CMP_W = 21;

  localparam int QUEUE_DEPTH = 4;

  localparam logic KIND_VOTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // one table operation handed from the front to the back
  typedef struct packed {
    logic                do_add;
    logic                do_read;
    logic                has_result;
    logic                status;
    logic [IMAGE_W-1:0]  index;
    logic [AMOUNT_W-1:0] amount;
  } op_t;

  // 65536 / sqrt(len), rounded half up, capped at 65535
  function automatic logic [ROM_W-1:0] rsqrt_entry(input int len);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned full;
    longint unsigned l;
    lo   = 0;
    hi   = 65536;
    full = 64'd1 << 32;
    l    = longint'(len);
    for (int i = 0; i < 18; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (mid * mid * l <= full) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
    end
    if ((2 * lo + 1) * (2 * lo + 1) * l <= (full << 2)) begin
      lo = lo + 1;
    end
    if (lo > 65535) begin
      lo = 65535;
    end
    return lo[ROM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bnva_queue.sv =====
// short op queue between the front and the back
`timescale 1ns / 1ps
`default_nettype none
module bnva_queue
  import bnva_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_push,
  input  wire op_t  q_din,
  output logic      q_full,
  input  wire logic q_pop,
  output op_t       q_dout,
  output logic      q_empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign q_dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push) begin
      slots[wr_ptr] <= q_din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (q_push && !q_pop) begin
        count <= count + CNT_W'(1);
      end else if (!q_push && q_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("op pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("op popped from an empty queue");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/bnva_front.sv =====
// front: takes items, tracks the open run and issues table ops in order
`timescale 1ns / 1ps
`default_nettype none
module bnva_front
  import bnva_pkg::*;
#(
  parameter int NUM_IMAGES   = DEF_NUM_IMAGES,
  parameter int MAX_RUN      = DEF_MAX_RUN,
  parameter int FEATURE_BITS = DEF_FEATURE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                kind,
  input  wire logic [FEAT_W-1:0]   feature_id,
  input  wire logic [IMAGE_W-1:0]  image_id,
  input  wire logic [WEIGHT_W-1:0] weight,
  input  wire logic                last_vote,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data,
  input  wire logic                clearing,
  output logic                     q_push,
  output op_t                      q_din,
  input  wire logic                q_full
);

  localparam int FB     = (FEATURE_BITS < FEAT_W) ? FEATURE_BITS : FEAT_W;
  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int ROMI_W = $clog2(MAX_RUN);
  localparam logic [IMG_CMP_W-1:0] IMG_LIMIT = IMG_CMP_W'(NUM_IMAGES);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [2:0] F_IDLE   = 3'd0;
  localparam logic [2:0] F_DECIDE = 3'd1;
  localparam logic [2:0] F_ROM    = 3'd2;
  localparam logic [2:0] F_MUL    = 3'd3;
  localparam logic [2:0] F_PUSHC  = 3'd4;
  localparam logic [2:0] F_UPDATE = 3'd5;
  localparam logic [2:0] F_RESULT = 3'd6;

  logic [ROM_W-1:0] rom [MAX_RUN];
  for (genvar g = 0; g < MAX_RUN; g++) begin : g_rom
    assign rom[g] = rsqrt_entry(g + 1);
  end

  logic [2:0]          state;
  logic                ret_update;
  logic                burst_enable;

  logic                it_kind;
  logic [FB-1:0]       it_feat;
  logic [IMAGE_W-1:0]  it_image;
  logic [WEIGHT_W-1:0] it_weight;
  logic                it_last;
  logic                it_valid;

  logic                run_open;
  logic [IMAGE_W-1:0]  run_image;
  logic [FB-1:0]       run_feature;
  logic [SUM_W-1:0]    run_sum;
  logic [RUN_W-1:0]    run_length;

  logic [ROM_W-1:0]    rom_q;
  logic [PROD_W-1:0]   prod;

  logic                in_valid;
  logic                close_first;
  logic                burst_vote;
  logic [RUN_W-1:0]    rom_idx_full;
  logic [PROD_W:0]     rounded;
  logic [AMOUNT_W-1:0] contrib;
  logic [SUM_W:0]      sum_ext;

  assign cfg_ready = 1'b1;
  assign full      = (state != F_IDLE) || clearing;

  assign in_valid = (image_id != '0) && ({{(IMG_CMP_W-IMAGE_W){1'b0}}, image_id} <= IMG_LIMIT);
  assign burst_vote = (it_kind == KIND_VOTE) && it_valid && burst_enable;

  always_comb begin
    close_first = 1'b0;
    if (it_kind == KIND_READ) begin
      close_first = it_valid && run_open;
    end else if (!it_valid) begin
      close_first = it_last && run_open;
    end else if (!burst_enable) begin
      close_first = run_open;
    end else begin
      close_first = run_open && ((run_feature != it_feat) || (run_image != it_image));
    end
  end

  assign rom_idx_full = run_length - RUN_W'(1);
  assign rounded      = {1'b0, prod} + (PROD_W+1)'(32768);
  // single votes pass their weight through unscaled
  assign contrib = (run_length <= RUN_W'(1)) ? AMOUNT_W'(run_sum)
                                             : rounded[PROD_W:ROM_W];
  assign sum_ext = {1'b0, run_sum} + (SUM_W+1)'(it_weight);

  always_comb begin
    q_push = 1'b0;
    q_din  = '0;
    if (state == F_PUSHC) begin
      q_push        = !q_full;
      q_din.do_add  = 1'b1;
      q_din.index   = run_image - IMAGE_W'(1);
      q_din.amount  = contrib;
    end else if (state == F_RESULT) begin
      q_push           = !q_full;
      q_din.has_result = 1'b1;
      q_din.status     = it_valid ? STATUS_OK : STATUS_RANGE;
      q_din.index      = it_image - IMAGE_W'(1);
      q_din.amount     = AMOUNT_W'(it_weight);
      if (it_valid) begin
        q_din.do_read = (it_kind == KIND_READ);
        q_din.do_add  = (it_kind == KIND_VOTE) && !burst_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      it_kind   <= kind;
      it_feat   <= feature_id[FB-1:0];
      it_image  <= image_id;
      it_weight <= weight;
      it_last   <= last_vote;
      it_valid  <= in_valid;
    end
    if (state == F_ROM) begin
      rom_q <= rom[rom_idx_full[ROMI_W-1:0]];
    end
    if (state == F_MUL) begin
      prod <= run_sum * rom_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      ret_update   <= 1'b0;
      burst_enable <= 1'b1;
      run_open     <= 1'b0;
      run_image    <= '0;
      run_feature  <= '0;
      run_sum      <= '0;
      run_length   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        burst_enable <= cfg_data;
      end
      unique case (state)
        F_IDLE: begin
          if (push && !full) begin
            state <= F_DECIDE;
          end
        end
        F_DECIDE: begin
          ret_update <= 1'b1;
          state      <= close_first ? F_ROM : F_UPDATE;
        end
        F_ROM: begin
          state <= F_MUL;
        end
        F_MUL: begin
          state <= F_PUSHC;
        end
        F_PUSHC: begin
          if (!q_full) begin
            run_open    <= 1'b0;
            run_image   <= '0;
            run_feature <= '0;
            run_sum     <= '0;
            run_length  <= '0;
            state       <= ret_update ? F_UPDATE : F_RESULT;
          end
        end
        F_UPDATE: begin
          if (burst_vote) begin
            if (run_open) begin
              run_sum <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
              if (run_length < RUN_W'(MAX_RUN)) begin
                run_length <= run_length + RUN_W'(1);
              end
            end else begin
              run_open    <= 1'b1;
              run_image   <= it_image;
              run_feature <= it_feat;
              run_sum     <= SUM_W'(it_weight);
              run_length  <= RUN_W'(1);
            end
          end
          // the last vote of a list closes the run it just joined
          if (burst_vote && it_last) begin
            ret_update <= 1'b0;
            state      <= F_ROM;
          end else begin
            state <= F_RESULT;
          end
        end
        F_RESULT: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bnva_back.sv =====
// back: clears the score table after reset, then runs queued ops on it
`timescale 1ns / 1ps
`default_nettype none
module bnva_back
  import bnva_pkg::*;
#(
  parameter int NUM_IMAGES = DEF_NUM_IMAGES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire op_t                q_dout,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    clearing,
  output logic                    empty,
  input  wire logic               pop,
  output logic [SCORE_W-1:0]      score,
  output logic                    status
);

  localparam int IDX_W = (NUM_IMAGES > 1) ? $clog2(NUM_IMAGES) : 1;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_MOD   = 2'd2;

  logic [SCORE_W-1:0] mem [NUM_IMAGES];

  logic [1:0]               state;
  logic [IDX_W-1:0]         clr_cnt;
  op_t                      cur;
  logic [SCORE_W-1:0]       rd_data;
  logic                     out_valid;

  logic [IDX_W+IMAGE_W-1:0] head_wide;
  logic [IDX_W+IMAGE_W-1:0] cur_wide;
  logic [IDX_W-1:0]         head_addr;
  logic [IDX_W-1:0]         cur_addr;
  logic [SCORE_W:0]         sum_ext;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [SCORE_W-1:0]       wdata;

  assign head_wide = {{IDX_W{1'b0}}, q_dout.index};
  assign cur_wide  = {{IDX_W{1'b0}}, cur.index};
  assign head_addr = head_wide[IDX_W-1:0];
  assign cur_addr  = cur_wide[IDX_W-1:0];

  assign clearing = (state == B_CLEAR);
  assign empty    = !out_valid;
  assign q_pop    = (state == B_IDLE) && !q_empty && (!out_valid || !q_dout.has_result);
  assign sum_ext  = {1'b0, rd_data} + (SCORE_W+1)'(cur.amount);

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = '0;
    if (state == B_CLEAR) begin
      we    = 1'b1;
      waddr = clr_cnt;
    end else if (state == B_MOD) begin
      we = cur.do_add || cur.do_read;
      if (cur.do_add) begin
        wdata = sum_ext[SCORE_W] ? SCORE_MAX : sum_ext[SCORE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (q_pop) begin
      rd_data <= mem[head_addr];
      cur     <= q_dout;
    end
    if (state == B_MOD && cur.has_result) begin
      score  <= cur.do_read ? rd_data : '0;
      status <= cur.status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == IDX_W'(NUM_IMAGES - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (q_pop) begin
            state <= B_MOD;
          end
        end
        B_MOD: begin
          if (cur.has_result) begin
            out_valid <= 1'b1;
          end
          state <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
      (state == B_CLEAR) |-> !q_pop)
    else $error("op taken during table clear");
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
      (state == B_MOD && cur.has_result) |=> out_valid)
    else $error("finished item result not presented");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/burst_normalized_vote_accumulator.sv =====
// top level of the burst normalized vote accumulator
// Votes and read-and-clear requests enter through a push/full queue port and each gives one
// result on the empty/pop side, in order. The front takes one item at a time; each open run
// that an item closes adds the steps registered reciprocal square root table lookup, multiply
// and issue, run by the run tracking sequencer. A four deep op queue feeds the back, which
// handles one table op at a time (registered table read, then update and write).
// After reset the back zeroes the score table, one entry per cycle, with full held high;
// configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
module burst_normalized_vote_accumulator
  import bnva_pkg::*;
#(
  parameter int NUM_IMAGES   = DEF_NUM_IMAGES,
  parameter int MAX_RUN      = DEF_MAX_RUN,
  parameter int FEATURE_BITS = DEF_FEATURE_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic                kind,
  input  wire logic [FEAT_W-1:0]   feature_id,
  input  wire logic [IMAGE_W-1:0]  image_id,
  input  wire logic [WEIGHT_W-1:0] weight,
  input  wire logic                last_vote,
  output logic                     empty,
  input  wire logic                pop,
  output logic [SCORE_W-1:0]       score,
  output logic                     status,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data
);

  logic clearing;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  op_t  q_din;
  op_t  q_dout;

  bnva_front #(
    .NUM_IMAGES  (NUM_IMAGES),
    .MAX_RUN     (MAX_RUN),
    .FEATURE_BITS(FEATURE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .feature_id(feature_id),
    .image_id  (image_id),
    .weight    (weight),
    .last_vote (last_vote),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .q_push    (q_push),
    .q_din     (q_din),
    .q_full    (q_full)
  );

  bnva_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .q_din  (q_din),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_dout (q_dout),
    .q_empty(q_empty)
  );

  bnva_back #(
    .NUM_IMAGES(NUM_IMAGES)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_dout  (q_dout),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .clearing(clearing),
    .empty   (empty),
    .pop     (pop),
    .score   (score),
    .status  (status)
  );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench of the burst normalized vote accumulator
`timescale 1ns / 1ps
module tb_top;
  import bnva_pkg::*;

  localparam int IMAGES      = DEF_NUM_IMAGES;
  localparam int RUN_CAP     = DEF_MAX_RUN;
  localparam int IDLE_PCT    = 17;
  localparam int QUIET_FROM  = 8000;
  localparam int QUIET_TO    = 12000;
  localparam int HOLD_AFTER  = 300;
  localparam int HOLD_CYCLES = 1500;
  localparam int DRAIN_WAIT  = 50;
  localparam logic BURST_OFF = 1'b0;
  localparam logic BURST_ON  = 1'b1;
  localparam logic [SCORE_W-1:0]  SCORE_TOP  = {SCORE_W{1'b1}};
  localparam logic [SUM_W-1:0]    SUM_TOP    = {SUM_W{1'b1}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = {WEIGHT_W{1'b1}};
  localparam logic [FEAT_W-1:0]   FEAT_TOP   = {FEAT_W{1'b1}};

  typedef struct {
    logic                kind;
    logic [FEAT_W-1:0]   feat;
    logic [IMAGE_W-1:0]  image;
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } vote_item_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               status;
  } vote_result_t;

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic                kind;
  logic [FEAT_W-1:0]   feature_id;
  logic [IMAGE_W-1:0]  image_id;
  logic [WEIGHT_W-1:0] weight;
  logic                last_vote;
  logic                empty;
  logic                pop;
  logic [SCORE_W-1:0]  score;
  logic                status;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;

  burst_normalized_vote_accumulator DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .feature_id (feature_id),
    .image_id   (image_id),
    .weight     (weight),
    .last_vote  (last_vote),
    .empty      (empty),
    .pop        (pop),
    .score      (score),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // predicted state of the score table and the open run
  logic [SCORE_W-1:0] score_ledger [1:IMAGES];
  logic [ROM_W-1:0]   rsqrt_tab [0:RUN_CAP-1];
  logic               run_live;
  logic [IMAGE_W-1:0] run_img;
  logic [FEAT_W-1:0]  run_feat;
  logic [SUM_W-1:0]   run_total;
  int                 run_len;
  logic               burst_on;

  vote_item_t   pending_items[$];
  vote_result_t awaited_results[$];
  logic         offer_live;
  int           cyc;
  int           results_seen;
  int           fail_count;
  int           hold_left;
  logic         hold_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // 65536 / sqrt(n), rounded half up and capped, built bit by bit
  function automatic logic [ROM_W-1:0] inv_sqrt_q16(input int n);
    longint unsigned v;
    longint unsigned t;
    longint unsigned nn;
    int b;
    v  = 0;
    nn = longint'(n);
    for (b = 16; b >= 0; b--) begin
      t = v | (64'd1 << b);
      if (t * t * nn <= (64'd1 << 32)) v = t;
    end
    if ((2 * v + 1) * (2 * v + 1) * nn <= (64'd1 << 34)) v = v + 1;
    if (v > 65535) v = 65535;
    return v[ROM_W-1:0];
  endfunction

  function automatic void ledger_add(input logic [IMAGE_W-1:0] img,
                                     input logic [SCORE_W-1:0] gain);
    logic [SCORE_W:0] s;
    s = score_ledger[img] + gain;
    score_ledger[img] = s[SCORE_W] ? SCORE_TOP : s[SCORE_W-1:0];
  endfunction

  function automatic void close_open_run();
    logic [47:0]        prod;
    logic [SCORE_W-1:0] gain;
    int                 idx;
    if (run_live) begin
      if (run_len <= 1) begin
        gain = SCORE_W'(run_total);
      end else begin
        idx  = (run_len - 1 >= RUN_CAP) ? RUN_CAP - 1 : run_len - 1;
        prod = run_total * rsqrt_tab[idx] + 32768;
        gain = SCORE_W'(prod >> 16);
      end
      ledger_add(run_img, gain);
      run_live  = 1'b0;
      run_img   = '0;
      run_feat  = '0;
      run_total = '0;
      run_len   = 0;
    end
  endfunction

  task automatic account_item(input vote_item_t it, output vote_result_t r);
    logic           in_range;
    logic [SUM_W:0] s;
    in_range = it.image >= 1 && it.image <= IMAGES;
    r.score  = '0;
    r.status = in_range ? STATUS_OK : STATUS_RANGE;
    if (it.kind == KIND_READ) begin
      if (in_range) begin
        close_open_run();
        r.score = score_ledger[it.image];
        score_ledger[it.image] = '0;
      end
    end else if (!in_range) begin
      // dropped vote keeps the run, but its last flag still closes it
      if (it.last) close_open_run();
    end else if (burst_on == BURST_OFF) begin
      close_open_run();
      ledger_add(it.image, SCORE_W'(it.weight));
    end else begin
      if (run_live && (run_feat != it.feat || run_img != it.image)) close_open_run();
      if (run_live) begin
        s = run_total + it.weight;
        run_total = s[SUM_W] ? SUM_TOP : s[SUM_W-1:0];
        if (run_len < RUN_CAP) run_len++;
      end else begin
        run_live  = 1'b1;
        run_img   = it.image;
        run_feat  = it.feat;
        run_total = SUM_W'(it.weight);
        run_len   = 1;
      end
      if (it.last) close_open_run();
    end
  endtask

  task automatic queue_item(input logic k, input logic [FEAT_W-1:0] f,
                            input logic [IMAGE_W-1:0] i, input logic [WEIGHT_W-1:0] w,
                            input logic l);
    pending_items.push_back('{k, f, i, w, l});
  endtask

  function automatic logic [IMAGE_W-1:0] pick_image();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return IMAGE_W'($urandom_range(8, 1));
    if (sel < 85) return IMAGE_W'($urandom_range(IMAGES, IMAGES - 7));
    return IMAGE_W'($urandom_range(IMAGES, 1));
  endfunction

  function automatic logic [IMAGE_W-1:0] pick_off_range();
    if ($urandom_range(3) == 0) return '0;
    return IMAGE_W'($urandom_range(8191, IMAGES + 1));
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 20) return WEIGHT_TOP;
    return WEIGHT_W'($urandom);
  endfunction

  // mostly runs of matching votes, with reads, loose votes and off-range noise
  task automatic queue_random_phase(input int count);
    int                  added;
    int                  shape;
    int                  run_n;
    int                  k;
    logic                heavy;
    logic [FEAT_W-1:0]   f;
    logic [IMAGE_W-1:0]  img;
    logic [WEIGHT_W-1:0] w;
    added = 0;
    while (added < count) begin
      shape = $urandom_range(99);
      if (shape < 60) begin
        f     = ($urandom_range(3) == 0) ? FEAT_W'($urandom) : FEAT_W'($urandom_range(7));
        img   = pick_image();
        heavy = 1'b0;
        if ($urandom_range(24) == 0) begin
          run_n = $urandom_range(200, 60);
          heavy = 1'($urandom_range(1));
        end else begin
          run_n = $urandom_range(6, 1);
        end
        for (k = 0; k < run_n; k++) begin
          if ($urandom_range(14) == 0)
            queue_item(KIND_VOTE, FEAT_W'($urandom), pick_off_range(),
                       WEIGHT_W'($urandom), 1'b0);
          w = heavy ? WEIGHT_TOP : pick_weight();
          queue_item(KIND_VOTE, f, img, w, (k == run_n - 1) ? 1'($urandom_range(1)) : 1'b0);
          added++;
        end
      end else if (shape < 80) begin
        queue_item(KIND_READ, FEAT_W'($urandom), pick_image(), WEIGHT_W'($urandom),
                   1'($urandom_range(1)));
        added++;
      end else if (shape < 92) begin
        queue_item(KIND_VOTE, FEAT_W'($urandom), pick_image(), pick_weight(),
                   1'($urandom_range(1)));
        added++;
      end else begin
        queue_item(1'($urandom_range(1)), FEAT_W'($urandom), pick_off_range(),
                   WEIGHT_W'($urandom), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || offer_live || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_burst(input logic v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    burst_on = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // item driver
  always @(negedge clk) begin
    logic quiet;
    quiet = cyc >= QUIET_FROM && cyc < QUIET_TO;
    if (!rst && !offer_live) begin
      if (pending_items.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        push       <= 1'b1;
        kind       <= pending_items[0].kind;
        feature_id <= pending_items[0].feat;
        image_id   <= pending_items[0].image;
        weight     <= pending_items[0].weight;
        last_vote  <= pending_items[0].last;
        offer_live <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    logic quiet;
    quiet = cyc >= QUIET_FROM && cyc < QUIET_TO;
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      pop       <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      pop <= quiet || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // monitor: check results first, then predict the item taken at this edge
  always @(posedge clk) begin
    vote_item_t   taken;
    vote_result_t want;
    vote_result_t got;
    cyc <= cyc + 1;
    if (!rst) begin
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none expected, actual score %h status %b",
                   $time, score, status);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (want.score !== score) begin
            $display("%0t: score mismatch, expected %h, actual %h", $time, want.score, score);
            fail_count++;
          end
          if (want.status !== status) begin
            $display("%0t: status mismatch, expected %b, actual %b",
                     $time, want.status, status);
            fail_count++;
          end
        end
      end
      if (push && !full) begin
        taken = '{kind, feature_id, image_id, weight, last_vote};
        account_item(taken, got);
        awaited_results.push_back(got);
        void'(pending_items.pop_front());
        offer_live <= 1'b0;
      end
    end
  end

  initial begin
    int i;
    rst          = 1'b1;
    push         = 1'b0;
    kind         = KIND_VOTE;
    feature_id   = '0;
    image_id     = '0;
    weight       = '0;
    last_vote    = 1'b0;
    pop          = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    offer_live   = 1'b0;
    cyc          = 0;
    results_seen = 0;
    fail_count   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    for (i = 1; i <= IMAGES; i++) score_ledger[i] = '0;
    for (i = 0; i < RUN_CAP; i++) rsqrt_tab[i] = inv_sqrt_q16(i + 1);
    run_live  = 1'b0;
    run_img   = '0;
    run_feat  = '0;
    run_total = '0;
    run_len   = 0;
    burst_on  = BURST_ON;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed part, burst grouping at its reset value
    queue_item(KIND_READ, 0, 1, 0, 1'b0);
    queue_item(KIND_VOTE, 0, 1, WEIGHT_TOP, 1'b0);
    queue_item(KIND_VOTE, 0, 1, WEIGHT_TOP, 1'b0);
    queue_item(KIND_VOTE, 0, 1, WEIGHT_TOP, 1'b1);
    queue_item(KIND_READ, FEAT_TOP, 1, WEIGHT_TOP, 1'b1);
    queue_item(KIND_VOTE, FEAT_TOP, IMAGE_W'(IMAGES), 1, 1'b0);
    // off-range vote inside a run leaves it open
    queue_item(KIND_VOTE, FEAT_TOP, 0, WEIGHT_TOP, 1'b0);
    queue_item(KIND_VOTE, FEAT_TOP, IMAGE_W'(IMAGES), 2, 1'b0);
    // off-range vote with last set still closes the run
    queue_item(KIND_VOTE, 0, IMAGE_W'(IMAGES + 1), 5, 1'b1);
    queue_item(KIND_READ, 0, IMAGE_W'(IMAGES), 0, 1'b0);
    queue_item(KIND_READ, 0, 0, 0, 1'b0);
    queue_item(KIND_READ, FEAT_TOP, 13'h1FFF, WEIGHT_TOP, 1'b1);
    queue_item(KIND_VOTE, 5, 7, 100, 1'b0);
    queue_item(KIND_VOTE, 5, 7, 200, 1'b0);
    // read of the image while its run is open
    queue_item(KIND_READ, 0, 7, 0, 1'b0);
    queue_item(KIND_VOTE, 5, 7, 300, 1'b0);
    queue_item(KIND_VOTE, 6, 7, 400, 1'b0);
    queue_item(KIND_VOTE, 6, 8, 500, 1'b1);
    queue_item(KIND_READ, 0, 7, 0, 1'b0);
    queue_item(KIND_READ, 0, 8, 0, 1'b0);
    queue_item(KIND_VOTE, 0, 2, 0, 1'b1);
    // left open across the switch to direct adding
    queue_item(KIND_VOTE, 9, 9, 24'h123456, 1'b0);

    write_burst(BURST_OFF);
    queue_item(KIND_VOTE, 9, 9, 24'h000010, 1'b0);
    queue_item(KIND_READ, 0, 9, 0, 1'b0);
    queue_random_phase(350);

    write_burst(BURST_ON);
    queue_random_phase(700);

    write_burst(BURST_OFF);
    queue_random_phase(300);

    write_burst(BURST_ON);
    queue_random_phase(450);

    wait_idle();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("burst_normalized_vote_accumulator regression: pass");
    end else begin
      $display("burst_normalized_vote_accumulator regression: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("burst_normalized_vote_accumulator regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bnva_pkg.sv
hw/rtl/bnva_queue.sv
hw/rtl/bnva_front.sv
hw/rtl/bnva_back.sv
hw/rtl/burst_normalized_vote_accumulator.sv
dv/tb_top.sv
